>>> hw/rtl/varint_length_prefix_deframer_assert.svh
// Assertion macros shared by the deframer RTL files.
`ifndef VARINT_LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define VARINT_LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define VLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define VLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/vlpd_pkg.sv
// Package: types and constants of the varint length-prefix deframer.
`default_nettype none

package vlpd_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int GROUP_BITS = 7;
  localparam int WORD_BITS  = 64;
  // Index of the last 7-bit group that still lands inside the word.
  localparam int LAST_GROUP      = (WORD_BITS - 1) / GROUP_BITS;
  // Bits of the last group that fit below the word's top.
  localparam int LAST_GROUP_BITS = WORD_BITS - LAST_GROUP * GROUP_BITS;
  localparam int GRP_W           = $clog2(LAST_GROUP + 1);
  localparam int CONT_POS        = BYTE_BITS - 1;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] payload_byte;
    logic                 last_of_message;
    status_t              status;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/varint_length_prefix_deframer.sv
// Top level: varint length-prefixed message deframer.
//
// Input channel (in_valid / in_stall / in_byte): one raw stream byte per
// request. Each message is a little-endian base-128 varint length followed
// by that many payload bytes. Length bytes give no output request.
// Output channel (out_valid / out_stall): one request per payload byte with
// last_of_message on the final byte, status 0. A zero length (status 1) or a
// varint that runs past 64 bits (status 2) gives one error request with
// payload_byte 0, after which every byte is swallowed until reset.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// Payload and error requests are registered in a two-entry result queue.
// Stall: the queue absorbs one stalled request; in_stall rises only when
// both entries are held, and it is a flop output (no path from out_stall).
// Reset (rst, synchronous, high): back to the length phase, queue emptied.
`default_nettype none

module varint_length_prefix_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [vlpd_pkg::BYTE_BITS-1:0] in_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [vlpd_pkg::BYTE_BITS-1:0]      payload_byte,
  output logic                                last_of_message,
  output logic [1:0]                          status
);
  import vlpd_pkg::*;

  logic take;       // input request accepted this cycle
  logic res_valid;  // accepted byte produces an output request
  res_t res;
  res_t out_res;
  logic q_full;

  // Accept whenever the result queue has a free entry.
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  vlpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  vlpd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign payload_byte    = out_res.payload_byte;
  assign last_of_message = out_res.last_of_message;
  assign status          = out_res.status;

endmodule

`default_nettype wire

>>> hw/rtl/vlpd_core.sv
// Deframer state: varint length accumulation, payload countdown, halt.
`default_nettype none

module vlpd_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           take,
  input  wire logic [vlpd_pkg::BYTE_BITS-1:0] in_byte,
  output logic                                res_valid,
  output vlpd_pkg::res_t                      res
);
  import vlpd_pkg::*;

  `include "varint_length_prefix_deframer_assert.svh"

  logic                 payload_phase, payload_phase_next;
  logic                 halted, halted_next;
  logic                 acc_nz, acc_nz_next;
  logic [GRP_W-1:0]     grp, grp_next;
  logic [WORD_BITS-1:0] count, count_next;

  logic [GROUP_BITS-1:0] group;
  logic                  cont;
  logic [WORD_BITS-1:0]  placed;
  logic                  placed_nz;
  logic                  new_nz;
  logic                  is_last;

  assign group     = in_byte[GROUP_BITS-1:0];
  assign cont      = in_byte[CONT_POS];
  assign placed_nz = |placed;
  assign new_nz    = acc_nz | placed_nz;
  assign is_last   = (count == WORD_BITS'(1));

  // Put the 7-bit group at its slot; the top slot keeps only its low bits.
  always_comb begin
    placed = '0;
    for (int k = 0; k < LAST_GROUP; k++) begin
      if (grp == GRP_W'(k)) begin
        placed[k*GROUP_BITS +: GROUP_BITS] = group;
      end
    end
    if (grp == GRP_W'(LAST_GROUP)) begin
      placed[LAST_GROUP*GROUP_BITS +: LAST_GROUP_BITS] = group[LAST_GROUP_BITS-1:0];
    end
  end

  always_comb begin
    payload_phase_next = payload_phase;
    halted_next        = halted;
    acc_nz_next        = acc_nz;
    grp_next           = grp;
    count_next         = count;
    res_valid          = 1'b0;
    res.payload_byte   = '0;
    res.last_of_message = 1'b0;
    res.status         = ST_PAYLOAD;
    if (take && !halted) begin
      if (payload_phase) begin
        // count doubles as length accumulator, so it ends at zero for the next length
        res_valid           = 1'b1;
        res.payload_byte    = in_byte;
        res.last_of_message = is_last;
        count_next          = count - WORD_BITS'(1);
        if (is_last) begin
          payload_phase_next = 1'b0;
          grp_next           = '0;
          acc_nz_next        = 1'b0;
        end
      end else begin
        count_next  = count | placed;
        acc_nz_next = new_nz;
        if (!cont) begin
          if (!new_nz) begin
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res.status  = ST_ZERO_LEN;
          end else begin
            payload_phase_next = 1'b1;
          end
        end else if (grp == GRP_W'(LAST_GROUP)) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res.status  = ST_TOO_LONG;
        end else begin
          grp_next = grp + GRP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_phase <= 1'b0;
      halted        <= 1'b0;
      acc_nz        <= 1'b0;
      grp           <= '0;
      count         <= '0;
    end else begin
      payload_phase <= payload_phase_next;
      halted        <= halted_next;
      acc_nz        <= acc_nz_next;
      grp           <= grp_next;
      count         <= count_next;
    end
  end

  `VLPD_ASSERT_NEXT(a_halt_sticks, halted, halted, "halt released without reset")
  `VLPD_ASSERT_NOW(a_payload_count_nz, payload_phase, count != '0,
                   "payload phase with zero bytes remaining")
  `VLPD_ASSERT_NEXT(a_error_halts, res_valid && (res.status != ST_PAYLOAD), halted,
                    "error result did not halt")

endmodule

`default_nettype wire

>>> hw/rtl/vlpd_outq.sv
// Two-entry result queue that decouples receiver stall from the input side.
`default_nettype none

module vlpd_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire vlpd_pkg::res_t push_res,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output vlpd_pkg::res_t      out_res
);
  import vlpd_pkg::*;

  `include "varint_length_prefix_deframer_assert.svh"

  res_t       mem [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       pop;

  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  `VLPD_ASSERT_NOW(a_fill_range, 1'b1, fill != 2'd3, "queue fill out of range")
  `VLPD_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
  `VLPD_ASSERT_NEXT(a_pop_drains, pop && !push, fill == $past(fill) - 2'd1,
                    "pop did not lower fill")

endmodule

`default_nettype wire

>>> tb/sv/varint_length_prefix_deframer_tb.sv
// Testbench for the varint length-prefix deframer: self-predicting, randomized traffic.
`default_nettype none

module varint_length_prefix_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vlpd_pkg::*;

  // Clock, reset and DUT ports.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] payload_byte;
  logic       last_of_message;
  logic [1:0] status;

  varint_length_prefix_deframer u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .payload_byte    (payload_byte),
    .last_of_message (last_of_message),
    .status          (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow deframer state, updated on every byte the DUT takes.
  logic        shadow_in_payload = 1'b0;
  logic        shadow_halted     = 1'b0;
  logic [63:0] shadow_length     = '0;
  int unsigned shadow_shift      = 0;
  logic [63:0] shadow_remaining  = '0;

  // Requests the output side still owes us, oldest first.
  res_t        pending_results[$];
  int unsigned mismatch_count = 0;

  // Sender pacing: bursts of random length separated by idle gaps.
  int unsigned burst_left = 0;

  // Receiver pacing: a stall mode that changes now and then, plus an
  // on-demand long hold-off to fill the DUT's output queue.
  int unsigned hold_req   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;

  function automatic void push_result(logic [7:0] b, logic last, status_t st);
    res_t r;
    r.payload_byte    = b;
    r.last_of_message = last;
    r.status          = st;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Per-byte deframing: varint length phase, then payload pass-through.
  function automatic void deframe_predict(logic [7:0] b);
    if (shadow_halted) return;
    if (shadow_in_payload) begin
      shadow_remaining = shadow_remaining - 64'd1;
      if (shadow_remaining == 64'd0) begin
        push_result(b, 1'b1, ST_PAYLOAD);
        shadow_in_payload = 1'b0;
        shadow_length     = '0;
        shadow_shift      = 0;
      end else begin
        push_result(b, 1'b0, ST_PAYLOAD);
      end
      return;
    end
    // Group bits shifted past bit 63 fall off the 64-bit accumulator.
    shadow_length = shadow_length | ({57'd0, b[6:0]} << shadow_shift);
    if (!b[7]) begin
      if (shadow_length == 64'd0) begin
        shadow_halted = 1'b1;
        push_result(8'h00, 1'b0, ST_ZERO_LEN);
      end else begin
        shadow_remaining  = shadow_length;
        shadow_in_payload = 1'b1;
      end
    end else if (shadow_shift + 7 >= 64) begin
      shadow_halted = 1'b1;
      push_result(8'h00, 1'b0, ST_TOO_LONG);
    end else begin
      shadow_shift = shadow_shift + 7;
    end
  endfunction

  // Input monitor: predict on every accepted request.
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall === 1'b0) deframe_predict(in_byte);
  end

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // Output checker: each accepted request against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected request byte=%02h last=%0b status=%0d",
                                payload_byte, last_of_message, status));
      end else begin
        want = pending_results.pop_front();
        if (payload_byte !== want.payload_byte || last_of_message !== want.last_of_message ||
            status !== want.status) begin
          note_mismatch($sformatf(
            "expected byte=%02h last=%0b status=%0d, got byte=%02h last=%0b status=%0d",
            want.payload_byte, want.last_of_message, want.status,
            payload_byte, last_of_message, status));
        end
      end
    end
  end

  // Receiver: own stall pattern, overridden by a counted hold-off on demand.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;                          // keep up
        1: out_stall <= ($urandom_range(0, 3) == 0);   // light stalls
        2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy stalls
        default: out_stall <= ((mode_left % 5) < 2);  // regular beat
      endcase
    end
  end

  // Offer one byte and hold it until taken. Valid is raised without
  // looking at in_stall; gaps only open between bursts.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                               : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    burst_left--;
  endtask

  // One framed message: a varint of the given byte count, then random payload.
  // Extra groups are zero padding; in the tenth group (shift 63) only bit 0
  // counts, so random upper bits go in there to show they get dropped.
  task automatic send_message(input logic [63:0] len, input int unsigned groups);
    logic [63:0] rest;
    logic [6:0]  grp;
    rest = len;
    for (int unsigned g = 0; g < groups; g++) begin
      grp  = rest[6:0];
      rest = rest >> 7;
      if (g == 9) grp = grp | (7'($urandom) & 7'h7E);
      send_byte({g != groups - 1, grp});
    end
    for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // Directed: smallest message, extreme payload bytes, padded lengths, and
  // high bits in the shift-63 group.
  task automatic test_directed;
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h80);
    // length 3 spelled with a redundant zero group
    send_byte(8'h83);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h55);
    // full ten-byte varint, dropped bits in the last group
    send_message(64'd1, 10);
    send_message(64'd2, 1);
  endtask

  // Random well-formed traffic: mostly short messages, some long ones
  // needing multi-byte lengths, a share with padded varints.
  task automatic test_random_messages(input int unsigned byte_budget);
    int unsigned spent;
    int unsigned pick;
    int unsigned groups;
    logic [63:0] len;
    spent = 0;
    while (spent < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      len = $urandom_range(1, 8);
      else if (pick < 90) len = $urandom_range(9, 64);
      else                len = $urandom_range(65, 300);
      groups = (len < 128) ? 1 : 2;
      if ($urandom_range(0, 3) == 0) groups = $urandom_range(groups, 10);
      send_message(len, groups);
      spent += groups + int'(len);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering a message, so
  // the output queue fills and in_stall has to rise.
  task automatic test_backpressure;
    hold_req = 300;
    burst_left = 400;
    send_message(64'd40, 1);
  endtask

  // One halting error (reset happens only once, so one kind per run),
  // then bytes that must be swallowed without any output.
  task automatic test_halt;
    if ($urandom_range(0, 1) == 0) begin
      send_message(64'd0, $urandom_range(1, 10));           // zero length
    end else begin
      repeat (10) send_byte({1'b1, 7'($urandom)});           // varint too long
    end
    repeat (20) send_byte(8'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_messages(700);
    test_backpressure();
    test_random_messages(700);
    test_halt();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // result queue is two deep and registered
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
